// ----- rtl/float_exp_taylor_series_top_defines.svh -----
// Assertion macros for the single-precision exponential block.
// No dependencies; included by the top level only.
`ifndef FLOAT_EXP_TAYLOR_SERIES_TOP_DEFINES_SVH
`define FLOAT_EXP_TAYLOR_SERIES_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FEXP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fexp assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fexp assertion failed");

`endif

// ----- rtl/fexp_pkg.sv -----
// Shared types and constants for the single-precision exponential block.
// No dependencies.
`timescale 1ns / 1ps

package fexp_pkg;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_42   = 32'h4228_0000;
  localparam logic [31:0] FP_INF  = 32'h7F80_0000;
  localparam logic [31:0] FP_ZERO = 32'h0000_0000;
  localparam logic [30:0] MAG_90  = 31'h42B4_0000;
  localparam logic [30:0] MAG_INF = 31'h7F80_0000;

  localparam int unsigned MAX_TERMS_DEF = 8192;
  localparam int unsigned K_W_DEF       = $clog2(MAX_TERMS_DEF + 2);

  typedef enum logic [1:0] {
    FX_MUL,
    FX_DIV,
    FX_ADD,
    FX_CVT
  } fx_op_t;

  typedef struct packed {
    logic        start;
    fx_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } fx_req_t;

endpackage

// ----- rtl/fexp_fpu.sv -----
// Iterative single-precision unit: multiply, divide, add (nonnegative), int-to-float.
// Depends on fexp_pkg.
`timescale 1ns / 1ps

module fexp_fpu #(
  parameter int unsigned KW = fexp_pkg::K_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fexp_pkg::fx_req_t req,
  output logic              done,
  output logic [31:0]       result
);
  import fexp_pkg::*;

  localparam int MW = 50;
  localparam int EW = 11;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_DIV,
    FS_NORM,
    FS_DENORM,
    FS_ROUND
  } fs_t;

  fs_t                   state_r;
  logic [MW-1:0]         m_r;
  logic signed [EW-1:0]  e_r;
  logic                  stk_r;
  logic [24:0]           rem_r;
  logic [23:0]           mb_r;
  logic [5:0]            cnt_r;
  logic                  done_r;
  logic [31:0]           result_r;

  // Operand unpack
  logic [7:0]            fa, fb;
  logic [23:0]           ma, mb;
  logic signed [EW-1:0]  ea, eb;
  logic                  a_inf, b_inf;

  assign fa    = req.a[30:23];
  assign fb    = req.b[30:23];
  assign ma    = {fa != 8'd0, req.a[22:0]};
  assign mb    = {fb != 8'd0, req.b[22:0]};
  assign ea    = (fa == 8'd0) ? EW'(1) : EW'({3'b000, fa});
  assign eb    = (fb == 8'd0) ? EW'(1) : EW'({3'b000, fb});
  assign a_inf = (fa == 8'hFF);
  assign b_inf = (fb == 8'hFF);

  // Multiply path
  logic [47:0] prod;
  assign prod = ma * mb;

  // Add path: align the smaller operand with sticky
  logic                 a_big;
  logic [23:0]          m_big, m_sml;
  logic signed [EW-1:0] e_big, e_sml, d_exp;
  logic [MW-1:0]        xs, xs_sh, xs_lost, m_add;
  logic                 add_stk;

  assign a_big   = (req.a[30:0] >= req.b[30:0]);
  assign m_big   = a_big ? ma : mb;
  assign m_sml   = a_big ? mb : ma;
  assign e_big   = a_big ? ea : eb;
  assign e_sml   = a_big ? eb : ea;
  assign d_exp   = e_big - e_sml;
  assign xs      = {1'b0, m_sml, 25'd0};
  assign xs_sh   = (d_exp >= EW'(MW)) ? '0 : (xs >> d_exp[5:0]);
  assign xs_lost = (d_exp >= EW'(MW)) ? xs : (xs & ((MW'(1) << d_exp[5:0]) - MW'(1)));
  assign add_stk = |xs_lost;
  assign m_add   = {1'b0, m_big, 25'd0} + xs_sh;

  // Divide first quotient bit
  logic        q0;
  logic [24:0] rem0;
  assign q0   = ({1'b0, ma} >= {1'b0, mb});
  assign rem0 = {1'b0, ma} - (q0 ? {1'b0, mb} : 25'd0);

  // Divide step
  logic [24:0] rem2, rem_nxt;
  logic        qb;
  assign rem2    = {rem_r[23:0], 1'b0};
  assign qb      = (rem2 >= {1'b0, mb_r});
  assign rem_nxt = rem2 - (qb ? {1'b0, mb_r} : 25'd0);

  // Round to nearest even
  logic [23:0]          mant, mant_f;
  logic                 guard, sticky, up;
  logic [24:0]          r25;
  logic signed [EW-1:0] e_f;
  logic [7:0]           exp_fld;
  logic [31:0]          rnd_bits;

  always_comb begin
    mant    = m_r[49:26];
    guard   = m_r[25];
    sticky  = (|m_r[24:0]) | stk_r;
    up      = guard & (sticky | mant[0]);
    r25     = {1'b0, mant} + 25'(up);
    if (r25[24]) begin
      mant_f = r25[24:1];
      e_f    = e_r + EW'(1);
    end else begin
      mant_f = r25[23:0];
      e_f    = e_r;
    end
    exp_fld = mant_f[23] ? e_f[7:0] : 8'd0;
    if (mant_f[23] && (e_f >= EW'(255))) begin
      rnd_bits = FP_INF;
    end else begin
      rnd_bits = {1'b0, exp_fld, mant_f[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      unique case (state_r)
        FS_IDLE: begin
          stk_r <= 1'b0;
          if (req.start) begin
            unique case (req.op)
              FX_MUL: begin
                if (a_inf || b_inf) begin
                  result_r <= FP_INF;
                  done_r   <= 1'b1;
                end else begin
                  m_r     <= {prod, 2'b00};
                  e_r     <= ea + eb - EW'(126);
                  state_r <= FS_NORM;
                end
              end
              FX_ADD: begin
                if (a_inf || b_inf) begin
                  result_r <= FP_INF;
                  done_r   <= 1'b1;
                end else begin
                  m_r     <= m_add;
                  e_r     <= e_big + EW'(1);
                  stk_r   <= add_stk;
                  state_r <= FS_NORM;
                end
              end
              FX_DIV: begin
                if (b_inf) begin
                  result_r <= FP_ZERO;
                  done_r   <= 1'b1;
                end else if (a_inf) begin
                  result_r <= FP_INF;
                  done_r   <= 1'b1;
                end else begin
                  m_r     <= MW'(q0);
                  rem_r   <= rem0;
                  mb_r    <= mb;
                  e_r     <= ea - eb + EW'(128);
                  cnt_r   <= 6'd48;
                  state_r <= FS_DIV;
                end
              end
              FX_CVT: begin
                m_r     <= {req.a[KW-1:0], (MW-KW)'(0)};
                e_r     <= EW'(126 + KW);
                state_r <= FS_NORM;
              end
              default: state_r <= FS_IDLE;
            endcase
          end
        end
        FS_DIV: begin
          // One quotient bit per cycle
          m_r   <= {m_r[MW-2:0], qb};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            stk_r   <= (rem_nxt != 25'd0);
            state_r <= FS_NORM;
          end
        end
        FS_NORM: begin
          if (m_r == '0) begin
            state_r <= FS_ROUND;
          end else if (!m_r[MW-1]) begin
            m_r <= {m_r[MW-2:0], 1'b0};
            e_r <= e_r - EW'(1);
          end else begin
            state_r <= FS_DENORM;
          end
        end
        FS_DENORM: begin
          // Shift into the subnormal range, collecting sticky
          if ((e_r < EW'(1)) && (m_r != '0)) begin
            m_r   <= {1'b0, m_r[MW-1:1]};
            stk_r <= stk_r | m_r[0];
            e_r   <= e_r + EW'(1);
          end else begin
            state_r <= FS_ROUND;
          end
        end
        FS_ROUND: begin
          result_r <= rnd_bits;
          done_r   <= 1'b1;
          state_r  <= FS_IDLE;
        end
        default: state_r <= FS_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

// ----- rtl/float_exp_taylor_series_top.sv -----
// e^x for one IEEE single-precision operand, one transaction at a time.
// Computation runs on the shared iterative unit in fexp_fpu, op codes from fexp_pkg.
// The series loop builds each term as term * (x/k) and accumulates it,
// stopping once x/k no longer exceeds x/(x*x+42) or after MAX_TERMS steps.
// Timing: specials (NaN, zero, infinities, magnitude above 90) raise out_valid
// in the cycle after acceptance. Otherwise setup (x*x, +42, divide), then
// per series term int-to-float of k, divide, multiply, add (the convert is
// slowest for small k), one more convert and divide for the step that ends
// the series, and the reciprocal of a negative input. The divide in the
// shared unit sets most of the time: one quotient bit per cycle, followed
// by one-bit normalize shifts. A term count near x*x+42 gives up to about
// 8100 terms for inputs near 90. The block takes no new transaction until
// the result has been taken.
`timescale 1ns / 1ps
`include "float_exp_taylor_series_top_defines.svh"

module float_exp_taylor_series_top #(
  parameter int unsigned MAX_TERMS = fexp_pkg::MAX_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_bits
);
  import fexp_pkg::*;

  // Wide enough to hold MAX_TERMS + 1 for the loop bound check
  localparam int unsigned KW = $clog2(MAX_TERMS + 2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_DEN,
    ST_THR,
    ST_KF,
    ST_Q,
    ST_TERM,
    ST_SUM,
    ST_INV,
    ST_OUT
  } st_t;

  st_t         state_r;
  fx_req_t     req_r;
  logic [31:0] x_r, thr_r, term_r, sum_r, out_r;
  logic        neg_r;
  logic [KW-1:0] k_r;

  logic        fu_done;
  logic [31:0] fu_res;

  fexp_fpu #(.KW(KW)) u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req_r),
    .done   (fu_done),
    .result (fu_res)
  );

  // Decode the incoming operand class
  logic [30:0] in_mag;
  assign in_mag = in_x_bits[30:0];

  logic [KW-1:0] k_inc;
  assign k_inc = k_r + KW'(1);

  always_ff @(posedge clk) begin
    req_r.start <= 1'b0;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            neg_r <= in_x_bits[31];
            x_r   <= {1'b0, in_mag};
            if (in_mag > MAG_INF) begin
              // NaN passes through untouched
              out_r   <= in_x_bits;
              state_r <= ST_OUT;
            end else if (in_mag == 31'd0) begin
              out_r   <= FP_ONE;
              state_r <= ST_OUT;
            end else if (in_mag > MAG_90) begin
              // Saturate, infinities included
              out_r   <= in_x_bits[31] ? FP_ZERO : FP_INF;
              state_r <= ST_OUT;
            end else begin
              req_r   <= '{start: 1'b1, op: FX_MUL, a: {1'b0, in_mag}, b: {1'b0, in_mag}};
              state_r <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          if (fu_done) begin
            req_r   <= '{start: 1'b1, op: FX_ADD, a: fu_res, b: FP_42};
            state_r <= ST_DEN;
          end
        end
        ST_DEN: begin
          if (fu_done) begin
            req_r   <= '{start: 1'b1, op: FX_DIV, a: x_r, b: fu_res};
            state_r <= ST_THR;
          end
        end
        ST_THR: begin
          if (fu_done) begin
            thr_r   <= fu_res;
            term_r  <= FP_ONE;
            sum_r   <= FP_ONE;
            k_r     <= KW'(1);
            req_r   <= '{start: 1'b1, op: FX_CVT, a: 32'(KW'(1)), b: FP_ZERO};
            state_r <= ST_KF;
          end
        end
        ST_KF: begin
          if (fu_done) begin
            req_r   <= '{start: 1'b1, op: FX_DIV, a: x_r, b: fu_res};
            state_r <= ST_Q;
          end
        end
        ST_Q: begin
          if (fu_done) begin
            // Both operands are nonnegative, so bit patterns order like values
            if (fu_res > thr_r) begin
              req_r   <= '{start: 1'b1, op: FX_MUL, a: term_r, b: fu_res};
              state_r <= ST_TERM;
            end else if (neg_r) begin
              req_r   <= '{start: 1'b1, op: FX_DIV, a: FP_ONE, b: sum_r};
              state_r <= ST_INV;
            end else begin
              out_r   <= sum_r;
              state_r <= ST_OUT;
            end
          end
        end
        ST_TERM: begin
          if (fu_done) begin
            term_r  <= fu_res;
            req_r   <= '{start: 1'b1, op: FX_ADD, a: sum_r, b: fu_res};
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (fu_done) begin
            sum_r <= fu_res;
            k_r   <= k_inc;
            if (32'(k_inc) > 32'(MAX_TERMS)) begin
              // Step bound reached: finish with the current sum
              if (neg_r) begin
                req_r   <= '{start: 1'b1, op: FX_DIV, a: FP_ONE, b: fu_res};
                state_r <= ST_INV;
              end else begin
                out_r   <= fu_res;
                state_r <= ST_OUT;
              end
            end else begin
              req_r   <= '{start: 1'b1, op: FX_CVT, a: 32'(k_inc), b: FP_ZERO};
              state_r <= ST_KF;
            end
          end
        end
        ST_INV: begin
          if (fu_done) begin
            out_r   <= fu_res;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold the result until taken
          if (out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_result_bits = out_r;

  `FEXP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `FEXP_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
  `FEXP_ASSERT_IMPL(a_k_bound, state_r == ST_KF || state_r == ST_Q, 32'(k_r) <= 32'(MAX_TERMS))

endmodule

// ----- bench/fexp_checker.sv -----
// Checker for the single-precision exponential block: watches both channels,
// predicts each result with exact single rounding and compares.
// Depends on fexp_pkg for the special-case constants.
`timescale 1ns / 1ps

module fexp_checker #(
  parameter int unsigned MAX_TERMS = fexp_pkg::MAX_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_x_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_result_bits,
  output int          fail_count,
  output int          waiting_count,
  output int          checked_count
);
  import fexp_pkg::*;

  logic [31:0] exp_fifo[$];
  logic [31:0] x_fifo[$];

  // Widen a single bit pattern to a real, exactly.
  function automatic real sgl_to_real(logic [31:0] b);
    real r;
    if (b[30:23] == 8'hFF) begin
      r = $bitstoreal({b[31], 11'h7FF, 52'd0});
    end else if (b[30:23] == 8'd0) begin
      r = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
      if (b[31]) r = -r;
    end else begin
      r = $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
    end
    return r;
  endfunction

  // Round a double to single, nearest-even, with subnormals and overflow.
  // One +,*,/ of two singles done in double then rounded here is correctly rounded.
  function automatic logic [31:0] real_to_sgl(real v);
    logic [63:0] d, sig, kept, rem, half, res;
    int          ex, sh;
    d = $realtobits(v);
    if (d[62:52] == 11'h7FF) return {d[63], 31'h7F80_0000};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    ex  = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 60) return {d[63], 31'd0};
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    // hidden bit in kept bumps the exponent by one, carry handled for free
    res = (ex >= -126) ? ((64'(ex + 126) << 23) + kept) : kept;
    if (res >= 64'h7F80_0000) res = 64'h7F80_0000;
    return {d[63], res[30:0]};
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    return real_to_sgl(sgl_to_real(a) * sgl_to_real(b));
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    return real_to_sgl(sgl_to_real(a) + sgl_to_real(b));
  endfunction

  function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
    return real_to_sgl(sgl_to_real(a) / sgl_to_real(b));
  endfunction

  function automatic logic [31:0] exp_of_bits(logic [31:0] x);
    logic [31:0] mag, sum, term, thr, q;
    mag = {1'b0, x[30:0]};
    if (x[30:0] > MAG_INF) return x;
    if (x[30:0] == 31'd0) return FP_ONE;
    if (x[30:0] > MAG_90) return x[31] ? FP_ZERO : FP_INF;
    sum  = FP_ONE;
    term = FP_ONE;
    thr  = f_div(mag, f_add(f_mul(mag, mag), FP_42));
    for (int unsigned k = 1; k <= MAX_TERMS; k++) begin
      q = f_div(mag, real_to_sgl(real'(k)));
      if (!(sgl_to_real(q) > sgl_to_real(thr))) break;
      term = f_mul(term, q);
      sum  = f_add(sum, term);
    end
    return x[31] ? f_div(FP_ONE, sum) : sum;
  endfunction

  assign waiting_count = exp_fifo.size();

  always @(posedge clk) begin
    logic [31:0] want, xin;
    if (!rst_n) begin
      fail_count    <= 0;
      checked_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_fifo.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result %h with nothing pending", out_result_bits);
        end else begin
          want = exp_fifo.pop_front();
          xin  = x_fifo.pop_front();
          checked_count <= checked_count + 1;
          if (out_result_bits !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch x=%h result_bits exp %h got %h", xin, want,
                       out_result_bits);
          end
        end
      end
      if (in_valid && in_ready) begin
        exp_fifo.push_back(exp_of_bits(in_x_bits));
        x_fifo.push_back(in_x_bits);
      end
    end
  end

endmodule

// ----- bench/float_exp_taylor_series_top_tb.sv -----
// Top of the testbench for float_exp_taylor_series_top: clock, reset, stimulus,
// receiver stalls and the verdict. Prediction lives in fexp_checker.
// Depends on fexp_pkg, fexp_checker and the block itself.
`timescale 1ns / 1ps

module float_exp_taylor_series_top_tb;
  import fexp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_x_bits = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_bits;

  int fail_count, waiting_count, checked_count;
  int sent_count = 0;
  int special_count = 0;
  bit stim_done = 1'b0;

  // Directed operands: signed zeros, NaNs of both kinds, infinities, the 90
  // boundary on both sides, largest finite, smallest subnormal, a few plain
  // values and a full-length series at exactly 90.
  localparam int N_DIR = 21;
  localparam logic [31:0] DIR_X [N_DIR] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
    FP_INF, 32'hFF80_0000, 32'h42B4_0001, 32'hC2B4_0001, 32'h7F7F_FFFF,
    32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001, FP_ONE, 32'hBF80_0000,
    32'h3F00_0000, 32'hC020_0000, 32'h4120_0000, 32'hC120_0000, 32'h3F7F_FFFF,
    32'h42B4_0000
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  float_exp_taylor_series_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_x_bits(in_x_bits),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_bits(out_result_bits)
  );

  fexp_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_x_bits(in_x_bits),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_bits(out_result_bits),
    .fail_count(fail_count), .waiting_count(waiting_count),
    .checked_count(checked_count)
  );

  // Random operand. Most are small magnitudes so each series stays short;
  // the rest are medium values, specials, subnormals and tiny normals.
  function automatic logic [31:0] pick_operand();
    int          sel;
    logic [7:0]  ex;
    sel = $urandom_range(0, 99);
    if (sel < 60)      ex = 8'($urandom_range(100, 127));
    else if (sel < 70) ex = 8'($urandom_range(127, 130));
    else if (sel < 80) ex = 8'($urandom_range(133, 255));
    else if (sel < 88) ex = 8'd0;
    else               ex = 8'($urandom_range(1, 99));
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  // Offer one transaction after a random gap; keep valid high across a
  // zero gap so it is never dropped and raised in the same step.
  task automatic send_operand(logic [31:0] x);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_x_bits <= x;
    if (x[30:0] > MAG_90 || x[30:0] == 31'd0) special_count++;
    sent_count++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender: directed list first, then random operands.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIR_X[i]) send_operand(DIR_X[i]);
    repeat (80) send_operand(pick_operand());
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stall before each result; once, hold off for a long
  // stretch so the block backs up and stops taking input.
  initial begin
    int stall, taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      stall = (taken == 40) ? 400 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Verdict: let the checker log the last transaction, drain, settle, report.
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d operands (%0d special or saturating), %0d results checked.",
             sent_count, special_count, checked_count);
    if (fail_count == 0 && waiting_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop for a hung block.
  initial begin
    #60_000_000;
    $display("timeout after %0d results", checked_count);
    $display("Regression FAIL");
    $finish;
  end

endmodule
